// ----- hw/rtl/pridt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pridt_pkg
// Shared constants for the pending request ID table: defaults, hash
// multiplier, slot marks and result status codes.
// ----------------------------------------------------------------------------
package pridt_pkg;

  // Default sizing
  localparam int TABLE_SLOTS_DEF = 2048;
  localparam int ID_BITS_DEF     = 32;
  localparam int TAG_BITS_DEF    = 32;

  // Fixed port field widths
  localparam int ID_W     = 32;
  localparam int TAG_W    = 32;
  localparam int LIVE_W   = 12;
  localparam int LIMIT_W  = 11;
  localparam int STATUS_W = 2;

  // Multiplicative hash constant
  localparam logic [31:0] HASH_MUL = 32'd2654435761;

  // In-flight limit after reset
  localparam logic [LIMIT_W-1:0] INFLIGHT_LIMIT_RST = 11'd1024;

  // Slot marks
  localparam logic [1:0] MARK_EMPTY = 2'd0;
  localparam logic [1:0] MARK_LIVE  = 2'd1;
  localparam logic [1:0] MARK_TOMB  = 2'd2;

  // Result status
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_LIMIT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_MISS  = 2'd3;

  // Request modes
  localparam logic MODE_REGISTER = 1'b0;
  localparam logic MODE_TAKE     = 1'b1;

endpackage
`default_nettype wire

// ----- hw/rtl/pridt_req_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pridt_req_if
// Request channel: register a new ID or take one back.
// ----------------------------------------------------------------------------
interface pridt_req_if;
  logic                        valid;
  logic                        ready;
  logic                        mode;
  logic [pridt_pkg::ID_W-1:0]  request_id;
  logic [pridt_pkg::TAG_W-1:0] user_tag;

  modport source (output valid, mode, request_id, user_tag, input ready);
  modport sink   (input valid, mode, request_id, user_tag, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/pridt_rsp_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pridt_rsp_if
// Response channel: one result per request.
// ----------------------------------------------------------------------------
interface pridt_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [pridt_pkg::STATUS_W-1:0] status;
  logic [pridt_pkg::ID_W-1:0]     assigned_id;
  logic [pridt_pkg::TAG_W-1:0]    tag_out;
  logic [pridt_pkg::LIVE_W-1:0]   live_count;

  modport source (output valid, status, assigned_id, tag_out, live_count, input ready);
  modport sink   (input valid, status, assigned_id, tag_out, live_count, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/pridt_hash.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pridt_hash
// Shared multiplicative hash: home slot = low index bits of key * HASH_MUL.
// Result is registered: it appears in the cycle after the key is presented.
// ----------------------------------------------------------------------------
module pridt_hash #(
  parameter int KEY_W = pridt_pkg::ID_BITS_DEF,
  parameter int IDX_W = 11
) (
  input  wire logic             clk,
  input  wire logic [KEY_W-1:0] key,
  output logic      [IDX_W-1:0] home
);

  logic [KEY_W+IDX_W-1:0] key_ext;
  logic [IDX_W-1:0]       key_lo;
  logic [IDX_W-1:0]       mul_lo;
  logic [IDX_W-1:0]       prod;

  // only the low index bits of the product matter
  always_comb begin
    key_ext = {IDX_W'(0), key};
    key_lo  = key_ext[IDX_W-1:0];
    mul_lo  = IDX_W'(pridt_pkg::HASH_MUL);
    prod    = key_lo * mul_lo;
  end

  always_ff @(posedge clk) begin
    home <= prod;
  end

endmodule
`default_nettype wire

// ----- hw/rtl/pridt_mem.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pridt_mem
// Slot memory, both banks: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module pridt_mem #(
  parameter int ADDR_W = 12,
  parameter int DATA_W = 66
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- hw/rtl/pending_request_id_table.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pending_request_id_table
// Outstanding request ID tracker: open-addressed hash table with linear
// probing, tombstone reuse and a two-bank rebuild.
// ----------------------------------------------------------------------------
// One request at a time. A request that ends early (limit, full, zero or
// out-of-range ID) skips the probe; a probed request reads one slot of the
// slot memory per probe (S_PRD) and then examines it (S_PEX). A register
// request that finds live entries plus tombstones at three quarters of the
// table or more first rebuilds into the other bank, or is refused as full
// if half the slots or more are live: the rebuild clears that bank, scans
// every source slot and moves each live entry. After reset a clearing pass
// over both banks runs before the first request is taken; writes to the
// in-flight limit are accepted during it.
module pending_request_id_table #(
  parameter int TABLE_SLOTS = pridt_pkg::TABLE_SLOTS_DEF,
  parameter int ID_BITS     = pridt_pkg::ID_BITS_DEF,
  parameter int TAG_BITS    = pridt_pkg::TAG_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [pridt_pkg::LIMIT_W-1:0]     cfg_wdata,
  pridt_req_if.sink                              req,
  pridt_rsp_if.source                            rsp
);

  localparam int IDX_W  = $clog2(TABLE_SLOTS);
  localparam int ADDR_W = IDX_W + 1;
  localparam int CNT_W  = IDX_W + 1;
  localparam int DATA_W = 2 + ID_BITS + TAG_BITS;
  localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(TABLE_SLOTS - 1);
  localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(2 * TABLE_SLOTS - 1);
  localparam logic [CNT_W+2:0]  FILL_LIM  = (CNT_W+3)'(3 * TABLE_SLOTS);
  localparam logic [CNT_W-1:0]  HALF      = CNT_W'(TABLE_SLOTS / 2);

  // sequencer states
  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_HASH   = 4'd2;
  localparam logic [3:0] S_PRD    = 4'd3;
  localparam logic [3:0] S_PEX    = 4'd4;
  localparam logic [3:0] S_RB_CLR = 4'd5;
  localparam logic [3:0] S_RB_RD  = 4'd6;
  localparam logic [3:0] S_RB_EX  = 4'd7;
  localparam logic [3:0] S_RB_HSH = 4'd8;
  localparam logic [3:0] S_RB_PRD = 4'd9;
  localparam logic [3:0] S_RB_PEX = 4'd10;
  localparam logic [3:0] S_DONE   = 4'd11;

  logic [3:0]                      state;
  logic [pridt_pkg::LIMIT_W-1:0]   inflight_limit;
  logic                            op_mode;
  logic [ID_BITS-1:0]              op_key;
  logic [TAG_BITS-1:0]             op_tag;
  logic                            active_bank;
  logic [CNT_W-1:0]                live;
  logic [CNT_W-1:0]                tomb;
  logic [ID_BITS:0]                counter;
  logic [IDX_W-1:0]                idx;
  logic                            first;
  logic [IDX_W-1:0]                n;
  logic                            have_tomb;
  logic [IDX_W-1:0]                tomb_idx;
  logic [IDX_W-1:0]                sidx;
  logic [ID_BITS-1:0]              rb_key;
  logic [TAG_BITS-1:0]             rb_tag;
  logic [ADDR_W-1:0]               clr_addr;
  logic [pridt_pkg::STATUS_W-1:0]  res_status;
  logic [ID_BITS-1:0]              res_id;
  logic [TAG_BITS-1:0]             res_tag;

  // memory port
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;
  logic [DATA_W-1:0] mem_rdata;

  // hash unit
  logic [ID_BITS-1:0] hash_key;
  logic [IDX_W-1:0]   hash_home;

  // probe decode
  logic [1:0]          rd_mark;
  logic [ID_BITS-1:0]  rd_key;
  logic [TAG_BITS-1:0] rd_tag;
  logic                rd_empty;
  logic                rd_tomb;
  logic                rd_live;
  logic                hit;
  logic                n_last;
  logic                have_eff;
  logic [IDX_W-1:0]    tomb_eff;
  logic [IDX_W-1:0]    ins_idx;
  logic [IDX_W-1:0]    rb_ins;
  logic [IDX_W-1:0]    cur_idx;
  logic [IDX_W-1:0]    nxt;

  // width adaption of port fields
  logic [ID_BITS+pridt_pkg::ID_W-1:0]    req_id_ext;
  logic [TAG_BITS+pridt_pkg::TAG_W-1:0]  req_tag_ext;
  logic [ID_BITS+pridt_pkg::ID_W-1:0]    res_id_ext;
  logic [TAG_BITS+pridt_pkg::TAG_W-1:0]  res_tag_ext;
  logic [CNT_W+pridt_pkg::LIVE_W-1:0]    live_ext;
  logic                                  id_fits;
  logic                                  at_limit;
  logic                                  fill_high;

  logic                            out_valid;
  logic [pridt_pkg::STATUS_W-1:0]  out_status;
  logic [pridt_pkg::ID_W-1:0]      out_id;
  logic [pridt_pkg::TAG_W-1:0]     out_tag;
  logic [pridt_pkg::LIVE_W-1:0]    out_live;

  always_comb begin
    req_id_ext  = {ID_BITS'(0), req.request_id};
    req_tag_ext = {TAG_BITS'(0), req.user_tag};
    res_id_ext  = {pridt_pkg::ID_W'(0), res_id};
    res_tag_ext = {pridt_pkg::TAG_W'(0), res_tag};
    live_ext    = {pridt_pkg::LIVE_W'(0), live};
    id_fits     = (req.request_id >> ID_BITS) == '0;
    at_limit    = (inflight_limit != '0) && (32'(live) >= 32'(inflight_limit));
    fill_high   = {(CNT_W+1)'(live) + (CNT_W+1)'(tomb), 2'b00} >= FILL_LIM;
  end

  // read data fields and probe decisions
  always_comb begin
    rd_mark  = mem_rdata[DATA_W-1 -: 2];
    rd_key   = mem_rdata[TAG_BITS +: ID_BITS];
    rd_tag   = mem_rdata[TAG_BITS-1:0];
    rd_empty = rd_mark == pridt_pkg::MARK_EMPTY;
    rd_tomb  = rd_mark == pridt_pkg::MARK_TOMB;
    rd_live  = rd_mark == pridt_pkg::MARK_LIVE;
    hit      = rd_live && (rd_key == op_key);
    n_last   = n == IDX_LAST;
    nxt      = idx + 1'b1;
    cur_idx  = first ? hash_home : idx;
    have_eff = have_tomb || rd_tomb;
    tomb_eff = have_tomb ? tomb_idx : idx;
    ins_idx  = have_eff ? tomb_eff : (rd_empty ? idx : nxt);
    rb_ins   = rd_empty ? idx : nxt;
    hash_key = (state == S_RB_HSH) ? rb_key : op_key;
  end

  // memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = {pridt_pkg::MARK_EMPTY, (DATA_W-2)'(0)};
    mem_raddr = {active_bank, cur_idx};
    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
      end
      S_PEX: begin
        if (op_mode == pridt_pkg::MODE_REGISTER) begin
          if (rd_empty || n_last) begin
            mem_we    = 1'b1;
            mem_waddr = {active_bank, ins_idx};
            mem_wdata = {pridt_pkg::MARK_LIVE, op_key, op_tag};
          end
        end else if (hit) begin
          mem_we    = 1'b1;
          mem_waddr = {active_bank, idx};
          mem_wdata = {pridt_pkg::MARK_TOMB, rd_key, rd_tag};
        end
      end
      S_RB_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = {~active_bank, idx};
      end
      S_RB_RD: begin
        mem_raddr = {active_bank, sidx};
      end
      S_RB_PRD: begin
        mem_raddr = {~active_bank, cur_idx};
      end
      S_RB_PEX: begin
        if (rd_empty || n_last) begin
          mem_we    = 1'b1;
          mem_waddr = {~active_bank, rb_ins};
          mem_wdata = {pridt_pkg::MARK_LIVE, rb_key, rb_tag};
        end
      end
      default: begin
      end
    endcase
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      inflight_limit <= pridt_pkg::INFLIGHT_LIMIT_RST;
    end else if (cfg_we) begin
      inflight_limit <= cfg_wdata;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_addr    <= '0;
      active_bank <= 1'b0;
      live        <= '0;
      tomb        <= '0;
      counter     <= (ID_BITS+1)'(1);
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == ADDR_LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req.valid) begin
            op_mode <= req.mode;
            op_tag  <= req_tag_ext[TAG_BITS-1:0];
            res_id  <= '0;
            res_tag <= '0;
            if (req.mode == pridt_pkg::MODE_REGISTER) begin
              op_key <= counter[ID_BITS-1:0];
              if (at_limit) begin
                res_status <= pridt_pkg::ST_LIMIT;
                state      <= S_DONE;
              end else if (counter[ID_BITS]) begin
                res_status <= pridt_pkg::ST_FULL;
                state      <= S_DONE;
              end else if (fill_high) begin
                if (live >= HALF) begin
                  res_status <= pridt_pkg::ST_FULL;
                  state      <= S_DONE;
                end else begin
                  idx   <= '0;
                  state <= S_RB_CLR;
                end
              end else begin
                state <= S_HASH;
              end
            end else begin
              op_key <= req_id_ext[ID_BITS-1:0];
              if (req.request_id == '0 || !id_fits) begin
                res_status <= pridt_pkg::ST_MISS;
                state      <= S_DONE;
              end else begin
                state <= S_HASH;
              end
            end
          end
        end
        S_HASH: begin
          first     <= 1'b1;
          n         <= '0;
          have_tomb <= 1'b0;
          state     <= S_PRD;
        end
        S_PRD: begin
          idx   <= cur_idx;
          first <= 1'b0;
          state <= S_PEX;
        end
        S_PEX: begin
          if (op_mode == pridt_pkg::MODE_REGISTER) begin
            if (rd_empty || n_last) begin
              live       <= live + 1'b1;
              counter    <= counter + 1'b1;
              res_status <= pridt_pkg::ST_OK;
              res_id     <= op_key;
              if (have_eff) begin
                tomb <= tomb - 1'b1;
              end
              state <= S_DONE;
            end else begin
              if (rd_tomb && !have_tomb) begin
                have_tomb <= 1'b1;
                tomb_idx  <= idx;
              end
              idx   <= nxt;
              n     <= n + 1'b1;
              state <= S_PRD;
            end
          end else begin
            if (hit) begin
              live       <= live - 1'b1;
              tomb       <= tomb + 1'b1;
              res_status <= pridt_pkg::ST_OK;
              res_tag    <= rd_tag;
              state      <= S_DONE;
            end else if (rd_empty || n_last) begin
              res_status <= pridt_pkg::ST_MISS;
              state      <= S_DONE;
            end else begin
              idx   <= nxt;
              n     <= n + 1'b1;
              state <= S_PRD;
            end
          end
        end
        // rebuild: clear target bank
        S_RB_CLR: begin
          idx <= nxt;
          if (idx == IDX_LAST) begin
            sidx  <= '0;
            state <= S_RB_RD;
          end
        end
        S_RB_RD: begin
          state <= S_RB_EX;
        end
        S_RB_EX: begin
          if (rd_live) begin
            rb_key <= rd_key;
            rb_tag <= rd_tag;
            state  <= S_RB_HSH;
          end else if (sidx == IDX_LAST) begin
            active_bank <= ~active_bank;
            tomb        <= '0;
            state       <= S_HASH;
          end else begin
            sidx  <= sidx + 1'b1;
            state <= S_RB_RD;
          end
        end
        S_RB_HSH: begin
          first <= 1'b1;
          n     <= '0;
          state <= S_RB_PRD;
        end
        S_RB_PRD: begin
          idx   <= cur_idx;
          first <= 1'b0;
          state <= S_RB_PEX;
        end
        S_RB_PEX: begin
          if (rd_empty || n_last) begin
            if (sidx == IDX_LAST) begin
              active_bank <= ~active_bank;
              tomb        <= '0;
              state       <= S_HASH;
            end else begin
              sidx  <= sidx + 1'b1;
              state <= S_RB_RD;
            end
          end else begin
            idx   <= nxt;
            n     <= n + 1'b1;
            state <= S_RB_PRD;
          end
        end
        S_DONE: begin
          if (!out_valid || rsp.ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && (!out_valid || rsp.ready)) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || rsp.ready)) begin
      out_status <= res_status;
      out_id     <= res_id_ext[pridt_pkg::ID_W-1:0];
      out_tag    <= res_tag_ext[pridt_pkg::TAG_W-1:0];
      out_live   <= live_ext[pridt_pkg::LIVE_W-1:0];
    end
  end

  assign req.ready       = state == S_IDLE;
  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.assigned_id = out_id;
  assign rsp.tag_out     = out_tag;
  assign rsp.live_count  = out_live;

  pridt_hash #(
    .KEY_W (ID_BITS),
    .IDX_W (IDX_W)
  ) u_hash (
    .clk  (clk),
    .key  (hash_key),
    .home (hash_home)
  );

  pridt_mem #(
    .ADDR_W (ADDR_W),
    .DATA_W (DATA_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

`ifndef NO_ASSERTIONS
  // live entries plus tombstones never exceed the table
  a_occupancy: assert property (@(posedge clk) disable iff (rst)
    (32'(live) + 32'(tomb)) <= TABLE_SLOTS)
    else $error("occupancy beyond table size");

  // one request at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request accepted while busy");

  // live count moves by at most one per cycle
  a_live_step: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && live != $past(live)) |->
      (live == $past(live) + 1'b1 || live == $past(live) - 1'b1))
    else $error("live count jumped");

  // a bank swap always leaves no tombstones
  a_swap_clean: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && active_bank != $past(active_bank)) |-> tomb == '0)
    else $error("tombstones left after rebuild");
`endif

endmodule
`default_nettype wire

// ----- sim/pridt_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pridt_checker
// Watches the request and response channels of the pending request ID table.
// Keeps its own copy of the two-bank hash table, predicts the result of each
// accepted request, and compares responses in order, field by field.
// ----------------------------------------------------------------------------
module pridt_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [pridt_pkg::LIMIT_W-1:0] cfg_wdata,
  pridt_req_if                          req,
  pridt_rsp_if                          rsp,
  output int                            mismatches,
  output int                            in_flight
);

  localparam int SLOTS = pridt_pkg::TABLE_SLOTS_DEF;

  typedef struct packed {
    logic [pridt_pkg::STATUS_W-1:0] status;
    logic [pridt_pkg::ID_W-1:0]     assigned_id;
    logic [pridt_pkg::TAG_W-1:0]    tag_out;
    logic [pridt_pkg::LIVE_W-1:0]   live_count;
  } outcome_t;

  // Shadow copy of the table
  logic [1:0]                  mark_q [2*SLOTS];
  logic [pridt_pkg::ID_W-1:0]  key_q  [2*SLOTS];
  logic [pridt_pkg::TAG_W-1:0] tag_q  [2*SLOTS];
  logic                        bank;
  int                          live;
  int                          tombs;
  longint                      next_id;
  int                          limit;

  outcome_t outcome_q[$];

  function automatic int home_of(logic [pridt_pkg::ID_W-1:0] id);
    logic [63:0] prod;
    prod = {32'd0, id} * {32'd0, pridt_pkg::HASH_MUL};
    return int'(prod[$clog2(SLOTS)-1:0]);
  endfunction

  // Move live entries into the other bank, dropping tombstones
  function automatic void rehash_bank();
    int src;
    int dst;
    int j;
    src = bank ? SLOTS : 0;
    dst = bank ? 0 : SLOTS;
    for (int i = 0; i < SLOTS; i++) mark_q[dst + i] = pridt_pkg::MARK_EMPTY;
    for (int i = 0; i < SLOTS; i++) begin
      if (mark_q[src + i] == pridt_pkg::MARK_LIVE) begin
        j = home_of(key_q[src + i]);
        for (int n = 0; n < SLOTS && mark_q[dst + j] != pridt_pkg::MARK_EMPTY; n++)
          j = (j + 1) % SLOTS;
        mark_q[dst + j] = pridt_pkg::MARK_LIVE;
        key_q[dst + j]  = key_q[src + i];
        tag_q[dst + j]  = tag_q[src + i];
      end
    end
    bank  = ~bank;
    tombs = 0;
  endfunction

  function automatic outcome_t predict_outcome(logic mode, logic [pridt_pkg::ID_W-1:0] id,
                                               logic [pridt_pkg::TAG_W-1:0] tag);
    outcome_t o;
    int base;
    int i;
    int tomb_at;
    logic found;
    o = '0;
    base = bank ? SLOTS : 0;
    if (mode == pridt_pkg::MODE_REGISTER) begin
      if (limit != 0 && live >= limit) begin
        o.status = pridt_pkg::ST_LIMIT;
      end else if (next_id > longint'(32'hFFFF_FFFF)) begin
        o.status = pridt_pkg::ST_FULL;
      end else if ((live + tombs) * 4 >= SLOTS * 3 && live * 2 >= SLOTS) begin
        o.status = pridt_pkg::ST_FULL;
      end else begin
        if ((live + tombs) * 4 >= SLOTS * 3) begin
          rehash_bank();
          base = bank ? SLOTS : 0;
        end
        i = home_of(next_id[pridt_pkg::ID_W-1:0]);
        tomb_at = -1;
        for (int n = 0; n < SLOTS && mark_q[base + i] != pridt_pkg::MARK_EMPTY; n++) begin
          if (mark_q[base + i] == pridt_pkg::MARK_TOMB && tomb_at < 0) tomb_at = i;
          i = (i + 1) % SLOTS;
        end
        if (tomb_at >= 0) begin
          i = tomb_at;
          tombs--;
        end
        mark_q[base + i] = pridt_pkg::MARK_LIVE;
        key_q[base + i]  = next_id[pridt_pkg::ID_W-1:0];
        tag_q[base + i]  = tag;
        live++;
        o.status      = pridt_pkg::ST_OK;
        o.assigned_id = next_id[pridt_pkg::ID_W-1:0];
        next_id++;
      end
    end else begin
      o.status = pridt_pkg::ST_MISS;
      found = 1'b0;
      if (id != '0) begin
        i = home_of(id);
        for (int n = 0; n < SLOTS && !found; n++) begin
          if (mark_q[base + i] == pridt_pkg::MARK_EMPTY) break;
          if (mark_q[base + i] == pridt_pkg::MARK_LIVE && key_q[base + i] == id) begin
            found = 1'b1;
            o.status  = pridt_pkg::ST_OK;
            o.tag_out = tag_q[base + i];
            mark_q[base + i] = pridt_pkg::MARK_TOMB;
            live--;
            tombs++;
          end else begin
            i = (i + 1) % SLOTS;
          end
        end
      end
    end
    o.live_count = live[pridt_pkg::LIVE_W-1:0];
    return o;
  endfunction

  // Track config, predict on request, compare on response
  always @(posedge clk) begin
    outcome_t want;
    outcome_t got;
    if (rst) begin
      for (int i = 0; i < 2*SLOTS; i++) mark_q[i] = pridt_pkg::MARK_EMPTY;
      bank       = 1'b0;
      live       = 0;
      tombs      = 0;
      next_id    = 1;
      limit      = int'(pridt_pkg::INFLIGHT_LIMIT_RST);
      mismatches = 0;
      outcome_q.delete();
    end else begin
      if (cfg_we) limit = int'(cfg_wdata);
      if (req.valid && req.ready)
        outcome_q.push_back(predict_outcome(req.mode, req.request_id, req.user_tag));
      if (rsp.valid && rsp.ready) begin
        got = {rsp.status, rsp.assigned_id, rsp.tag_out, rsp.live_count};
        if (outcome_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: response with no request outstanding: %h", $realtime, got);
        end else begin
          want = outcome_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch exp st=%0d id=%h tag=%h live=%0d got st=%0d id=%h tag=%h live=%0d",
                       $realtime, want.status, want.assigned_id, want.tag_out,
                       want.live_count, got.status, got.assigned_id, got.tag_out,
                       got.live_count);
          end
        end
      end
    end
    in_flight = outcome_q.size();
  end

endmodule

// ----- sim/tb_pending_request_id_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pending_request_id_table
// Drives register and take requests through directed cases, a full fill to
// the would-grow point, a drain that forces a bank rebuild, and random mixes
// under several in-flight limits; the checker module judges every response.
// ----------------------------------------------------------------------------
module tb_pending_request_id_table;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_we = 1'b0;
  logic [pridt_pkg::LIMIT_W-1:0] cfg_wdata = '0;
  int                            mismatches;
  int                            in_flight;
  int                            burst_left = 0;
  int                            regs_sent = 0;
  int                            stall_mode = 0;

  pridt_req_if req ();
  pridt_rsp_if rsp ();

  pending_request_id_table dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req),
    .rsp       (rsp)
  );

  pridt_checker chk (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .req        (req),
    .rsp        (rsp),
    .mismatches (mismatches),
    .in_flight  (in_flight)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Response stalls: a randomly chosen pattern holds ready high, mostly high or mostly low
  always @(negedge clk) begin
    int cyc;
    cyc = int'($realtime / 10.0);
    if (cyc % 200 == 0) stall_mode = $urandom_range(0, 2);
    case (stall_mode)
      0: rsp.ready = 1'b1;
      1: rsp.ready = ($urandom_range(0, 3) != 0);
      default: rsp.ready = ($urandom_range(0, 3) == 0);
    endcase
  end

  // Send one request; bursts with random gaps between them
  task automatic send_request(logic mode, logic [pridt_pkg::ID_W-1:0] id,
                              logic [pridt_pkg::TAG_W-1:0] tag);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        req.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    req.valid      = 1'b1;
    req.mode       = mode;
    req.request_id = id;
    req.user_tag   = tag;
    if (mode == pridt_pkg::MODE_REGISTER) regs_sent++;
    burst_left--;
    do @(posedge clk); while (!req.ready);
    @(negedge clk);
  endtask

  task automatic register_one(logic [pridt_pkg::TAG_W-1:0] tag);
    send_request(pridt_pkg::MODE_REGISTER, $urandom, tag);
  endtask

  task automatic take_one(logic [pridt_pkg::ID_W-1:0] id);
    send_request(pridt_pkg::MODE_TAKE, id, $urandom);
  endtask

  // Random mix: mostly known IDs, some noise
  task automatic random_mix(int count, int reg_pct);
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 99) < reg_pct) register_one($urandom);
      else if ($urandom_range(0, 9) == 0) take_one($urandom);
      else take_one($urandom_range(1, regs_sent + 2));
    end
  endtask

  // Limit writes only when the block is idle
  task automatic write_limit(logic [pridt_pkg::LIMIT_W-1:0] value);
    req.valid = 1'b0;
    burst_left = 0;
    while (in_flight != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  initial begin
    req.valid      = 1'b0;
    req.mode       = pridt_pkg::MODE_REGISTER;
    req.request_id = '0;
    req.user_tag   = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: tag extremes, hits, misses, zero and all-ones IDs
    write_limit(11'd1024);
    register_one(32'h0000_0000);
    register_one(32'hFFFF_FFFF);
    register_one(32'h5A5A_A5A5);
    take_one(32'd1);
    take_one(32'd1);
    take_one(32'd0);
    take_one(32'hFFFF_FFFF);
    take_one(32'd2);
    take_one(32'd3);
    register_one(32'hA5A5_5A5A);
    take_one(32'd4);
    take_one(32'd5);

    // Small limit: fourth register is refused
    write_limit(11'd3);
    register_one($urandom);
    register_one($urandom);
    register_one($urandom);
    register_one($urandom);
    take_one(32'd6);
    register_one($urandom);

    // Top of the limit range
    write_limit(11'h7FF);
    random_mix(30, 55);

    // No limit: fill until the table would have to grow
    write_limit(11'd0);
    for (int k = 0; k < 1545; k++) register_one($urandom);
    // Drain enough to drop below half, then registers force a rebuild
    for (int k = 1; k <= 560; k++) take_one(k);
    random_mix(30, 60);

    write_limit(11'd1024);
    random_mix(20, 50);

    req.valid = 1'b0;
    while (in_flight != 0) @(negedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0) $display("tb_pending_request_id_table: PASS");
    else $display("tb_pending_request_id_table: FAIL");
    $finish;
  end

  initial begin
    #200ms;
    $display("tb_pending_request_id_table: FAIL");
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/pridt_pkg.sv
hw/rtl/pridt_req_if.sv
hw/rtl/pridt_rsp_if.sv
hw/rtl/pridt_hash.sv
hw/rtl/pridt_mem.sv
hw/rtl/pending_request_id_table.sv
sim/pridt_checker.sv
sim/tb_pending_request_id_table.sv
